@@ rtl/rmq_pkg.sv @@
// Shared types and constants for the range majority query block.
package rmq_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DATA_W  = 32;
    localparam int LEN_W   = 11;
    localparam int CNT_W   = ADDR_W + 1;

    localparam logic [LEN_W-1:0] DEPTH_LIMIT        = LEN_W'(DEPTH);
    localparam logic [LEN_W-1:0] ARRAY_LENGTH_RESET = LEN_W'(1024);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic [ADDR_W-1:0]        address;
        logic signed [DATA_W-1:0] value;
        logic [ADDR_W-1:0]        left;
        logic [ADDR_W-1:0]        right;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] majority_value;
        logic                     has_majority;
        logic                     out_of_range;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VOTE,
        ST_VOTE_END,
        ST_COUNT,
        ST_COUNT_END,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_write;
        logic query_latch;
        logic issue;
        logic rewind;
        logic count_mode;
        logic load_result;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic idx_at_hi;
        logic query_oor;
    } dp_status_t;

endpackage

@@ rtl/rmq_ram.sv @@
// Generic single-port RAM with registered read data.
module rmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rmq_datapath.sv @@
// Datapath: element store, bound registers, vote and count accumulators, result register.
module rmq_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rmq_pkg::in_item_t       in_data,
    input  logic                    cfg_write_en,
    input  logic [rmq_pkg::LEN_W-1:0] cfg_write_data,
    input  rmq_pkg::dp_cmd_t        cmd,
    output rmq_pkg::dp_status_t     status,
    output rmq_pkg::out_item_t      out_data
);

    logic [rmq_pkg::LEN_W-1:0]  array_length_reg;
    logic [rmq_pkg::ADDR_W-1:0] lo_reg, lo_next;
    logic [rmq_pkg::ADDR_W-1:0] hi_reg, hi_next;
    logic [rmq_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic signed [rmq_pkg::DATA_W-1:0] cand_reg, cand_next;
    logic [rmq_pkg::CNT_W-1:0]  votes_reg, votes_next;
    logic [rmq_pkg::CNT_W-1:0]  hits_reg, hits_next;
    logic                       oor_reg, oor_next;
    logic                       rd_pending_reg;
    rmq_pkg::out_item_t         out_reg, out_next;

    logic [rmq_pkg::ADDR_W-1:0] in_lo, in_hi;
    logic [rmq_pkg::LEN_W-1:0]  limit;
    logic                       in_oor;
    logic [rmq_pkg::ADDR_W-1:0] ram_addr;
    logic [rmq_pkg::DATA_W-1:0] ram_rdata;
    logic signed [rmq_pkg::DATA_W-1:0] rd_value;
    logic [rmq_pkg::LEN_W-1:0]  range_len;
    logic [rmq_pkg::CNT_W:0]    hits_x2;

    function automatic logic [rmq_pkg::LEN_W-1:0] LEN_W_SUB(
        input logic [rmq_pkg::ADDR_W-1:0] hi,
        input logic [rmq_pkg::ADDR_W-1:0] lo
    );
        LEN_W_SUB = {1'b0, hi} - {1'b0, lo} + rmq_pkg::LEN_W'(1);
    endfunction

    // reversed bounds are swapped
    assign in_lo = (in_data.left > in_data.right) ? in_data.right : in_data.left;
    assign in_hi = (in_data.left > in_data.right) ? in_data.left  : in_data.right;
    assign limit = (array_length_reg > rmq_pkg::DEPTH_LIMIT) ? rmq_pkg::DEPTH_LIMIT
                                                             : array_length_reg;

    assign in_oor = ({1'b0, in_hi} >= limit);
    assign status = '{idx_at_hi: (idx_reg == hi_reg), query_oor: in_oor};

    assign ram_addr = cmd.load_write ? in_data.address : idx_reg;
    assign rd_value = $signed(ram_rdata);

    rmq_ram #(
        .WIDTH (rmq_pkg::DATA_W),
        .DEPTH (rmq_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load_write),
        .addr  (ram_addr),
        .wdata (in_data.value),
        .rdata (ram_rdata)
    );

    assign range_len = LEN_W_SUB(hi_reg, lo_reg);
    assign hits_x2   = {hits_reg, 1'b0};

    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        cand_next  = cand_reg;
        votes_next = votes_reg;
        hits_next  = hits_reg;
        oor_next   = oor_reg;
        out_next   = out_reg;

        if (cmd.query_latch)
        begin
            lo_next    = in_lo;
            hi_next    = in_hi;
            idx_next   = in_lo;
            votes_next = '0;
            hits_next  = '0;
            oor_next   = in_oor;
        end
        else if (cmd.rewind)
        begin
            idx_next = lo_reg;
        end
        else if (cmd.issue)
        begin
            idx_next = idx_reg + rmq_pkg::ADDR_W'(1);
        end

        // read data lands in the cycle after its address
        if (rd_pending_reg)
        begin
            if (cmd.count_mode)
            begin
                if (rd_value == cand_reg)
                begin
                    hits_next = hits_reg + rmq_pkg::CNT_W'(1);
                end
            end
            else if (votes_reg == '0)
            begin
                cand_next  = rd_value;
                votes_next = rmq_pkg::CNT_W'(1);
            end
            else if (rd_value == cand_reg)
            begin
                votes_next = votes_reg + rmq_pkg::CNT_W'(1);
            end
            else
            begin
                votes_next = votes_reg - rmq_pkg::CNT_W'(1);
            end
        end

        if (cmd.load_result)
        begin
            out_next = '0;
            if (oor_reg)
            begin
                out_next.out_of_range = 1'b1;
            end
            else if (hits_x2 > {1'b0, range_len})
            begin
                out_next.majority_value = cand_reg;
                out_next.has_majority   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            array_length_reg <= rmq_pkg::ARRAY_LENGTH_RESET;
            rd_pending_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                array_length_reg <= cfg_write_data;
            end
            rd_pending_reg <= cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        idx_reg   <= idx_next;
        cand_reg  <= cand_next;
        votes_reg <= votes_next;
        hits_reg  <= hits_next;
        oor_reg   <= oor_next;
        out_reg   <= out_next;
    end

    assign out_data = out_reg;

endmodule

@@ rtl/rmq_ctrl.sv @@
// Controller: sequences the vote pass, the count pass and the result transfer.
module rmq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  rmq_pkg::dp_status_t status,
    output rmq_pkg::dp_cmd_t    cmd
);

    rmq_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            accept;
    logic            out_free;

    assign accept   = in_valid && (state_reg == rmq_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rmq_pkg::ST_IDLE:
            begin
                if (accept && (in_cmd == rmq_pkg::CMD_QUERY))
                begin
                    state_next = status.query_oor ? rmq_pkg::ST_FINISH : rmq_pkg::ST_VOTE;
                end
            end
            rmq_pkg::ST_VOTE:
            begin
                if (status.idx_at_hi)
                begin
                    state_next = rmq_pkg::ST_VOTE_END;
                end
            end
            rmq_pkg::ST_VOTE_END:
            begin
                state_next = rmq_pkg::ST_COUNT;
            end
            rmq_pkg::ST_COUNT:
            begin
                if (status.idx_at_hi)
                begin
                    state_next = rmq_pkg::ST_COUNT_END;
                end
            end
            rmq_pkg::ST_COUNT_END:
            begin
                state_next = rmq_pkg::ST_FINISH;
            end
            rmq_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = rmq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmq_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            rmq_pkg::ST_IDLE:
            begin
                in_stall        = 1'b0;
                cmd.load_write  = accept && (in_cmd == rmq_pkg::CMD_LOAD);
                cmd.query_latch = accept && (in_cmd == rmq_pkg::CMD_QUERY);
            end
            rmq_pkg::ST_VOTE:
            begin
                cmd.issue = 1'b1;
            end
            rmq_pkg::ST_VOTE_END:
            begin
                cmd.rewind = 1'b1;
            end
            rmq_pkg::ST_COUNT:
            begin
                cmd.issue      = 1'b1;
                cmd.count_mode = 1'b1;
            end
            rmq_pkg::ST_COUNT_END:
            begin
                cmd.count_mode = 1'b1;
            end
            rmq_pkg::ST_FINISH:
            begin
                cmd.load_result = out_free;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/range_majority_query.sv @@
// Top level: strict-majority range query over a loaded array of signed words.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   in_data  (in_item_t)
//  out      output     out_valid / out_stall out_data (out_item_t)
//  cfg      input      cfg_write_en          cfg_write_data (array_length)
//
// A load is written as it is accepted and leaves the block free. A query walks the
// element store twice, once for the vote and once for the count, one read per cycle
// through the single RAM port. A query with a bound out of range skips both walks.
// Reset clears control state and sets array_length to 1024; the element store is not
// cleared. A stalled result does not block the next transfer in; a finished query
// waits only while the result register is occupied and stalled.
module range_majority_query (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  rmq_pkg::in_item_t         in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output rmq_pkg::out_item_t        out_data,
    input  logic                      cfg_write_en,
    input  logic [rmq_pkg::LEN_W-1:0] cfg_write_data
);

    rmq_pkg::dp_cmd_t    dp_cmd;
    rmq_pkg::dp_status_t dp_status;

    rmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (in_data.cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    rmq_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_data        (in_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (dp_cmd),
        .status         (dp_status),
        .out_data       (out_data)
    );

    a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_of_range |->
            !out_data.has_majority && (out_data.majority_value == '0))
        else $error("out-of-range result carries a value");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.has_majority |-> (out_data.majority_value == '0))
        else $error("result without majority has nonzero value");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.cmd == rmq_pkg::CMD_QUERY) |=> in_stall)
        else $error("query transfer did not make the block busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.cmd == rmq_pkg::CMD_LOAD) |=> !in_stall)
        else $error("load transfer left the block busy");

endmodule

@@ test/range_majority_query_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for range_majority_query: element loads, majority queries, length register.
module range_majority_query_tb;

    localparam int QUIET_LIMIT = 20000;

    localparam logic signed [rmq_pkg::DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
    localparam logic signed [rmq_pkg::DATA_W-1:0] MOST_POSITIVE = 32'sh7fff_ffff;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    rmq_pkg::in_item_t         in_data;
    logic                      out_valid;
    logic                      out_stall;
    rmq_pkg::out_item_t        out_data;
    logic                      cfg_write_en;
    logic [rmq_pkg::LEN_W-1:0] cfg_write_data;

    // mirror of the block: element contents, which entries were loaded, usable length
    logic signed [rmq_pkg::DATA_W-1:0] store_mirror [rmq_pkg::DEPTH];
    bit                                loaded [rmq_pkg::DEPTH];
    logic [rmq_pkg::LEN_W-1:0]         length_mirror = rmq_pkg::ARRAY_LENGTH_RESET;
    rmq_pkg::out_item_t                pending_answers [$];

    int error_count     = 0;
    int items_sent      = 0;
    int holdoff_request = 0;
    int quiet_cycles    = 0;
    bit idling_on       = 1'b1;
    bit offering        = 1'b0;

    range_majority_query dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int usable_length();
        return (length_mirror > rmq_pkg::DEPTH) ? rmq_pkg::DEPTH : int'(length_mirror);
    endfunction

    // majority answer for one accepted transfer; loads only update the mirror
    function automatic void predict_item(rmq_pkg::in_item_t it);
        rmq_pkg::out_item_t                answer;
        int                                lo;
        int                                hi;
        int                                votes;
        int                                hits;
        logic signed [rmq_pkg::DATA_W-1:0] cand;
        if (it.cmd == rmq_pkg::CMD_LOAD)
        begin
            store_mirror[it.address] = it.value;
            loaded[it.address] = 1'b1;
            return;
        end
        lo = it.left;
        hi = it.right;
        if (lo > hi)
            {lo, hi} = {hi, lo};
        answer = '0;
        if (hi >= usable_length())
            answer.out_of_range = 1'b1;
        else
        begin
            votes = 0;
            hits  = 0;
            cand  = '0;
            for (int i = lo; i <= hi; i++)
            begin
                if (votes == 0)
                begin
                    cand  = store_mirror[i];
                    votes = 1;
                end
                else if (store_mirror[i] == cand)
                    votes++;
                else
                    votes--;
            end
            for (int i = lo; i <= hi; i++)
                if (store_mirror[i] == cand)
                    hits++;
            if (2 * hits > hi - lo + 1)
            begin
                answer.majority_value = cand;
                answer.has_majority   = 1'b1;
            end
        end
        pending_answers.insert(pending_answers.size(), answer);
    endfunction

    // a query is safe if it reads nothing or reads only loaded entries
    function automatic bit reads_loaded(int l, int r);
        int lo;
        int hi;
        lo = (l < r) ? l : r;
        hi = (l < r) ? r : l;
        if (hi >= usable_length())
            return 1'b1;
        for (int i = lo; i <= hi; i++)
            if (!loaded[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic signed [rmq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 6))
            0:       return MOST_NEGATIVE;
            1:       return MOST_POSITIVE;
            2:       return '0;
            3:       return -32'sd1;
            4:       return rmq_pkg::DATA_W'($urandom_range(0, 8)) - 32'sd4;
            default: return $urandom();
        endcase
    endfunction

    function automatic rmq_pkg::in_item_t make_load(int addr,
                                                    logic signed [rmq_pkg::DATA_W-1:0] val);
        rmq_pkg::in_item_t it;
        it.cmd     = rmq_pkg::CMD_LOAD;
        it.address = rmq_pkg::ADDR_W'(addr);
        it.value   = val;
        it.left    = rmq_pkg::ADDR_W'($urandom());
        it.right   = rmq_pkg::ADDR_W'($urandom());
        return it;
    endfunction

    function automatic rmq_pkg::in_item_t make_query(int l, int r);
        rmq_pkg::in_item_t it;
        it.cmd     = rmq_pkg::CMD_QUERY;
        it.address = rmq_pkg::ADDR_W'($urandom());
        it.value   = $urandom();
        it.left    = rmq_pkg::ADDR_W'(l);
        it.right   = rmq_pkg::ADDR_W'(r);
        return it;
    endfunction

    // valid stays high between back-to-back transfers; it drops only on a gap
    task automatic send_item(rmq_pkg::in_item_t it);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            if (offering)
                in_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        offering = 1'b1;
        do @(posedge clk); while (in_stall);
        predict_item(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        if (offering)
            in_valid <= 1'b0;
        offering = 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        // a load may still be in flight
        repeat (6) @(posedge clk);
    endtask

    task automatic write_length(logic [rmq_pkg::LEN_W-1:0] len);
        wait_drained();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= len;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        length_mirror = len;
    endtask

    // window content leans toward one dominant value, the rest near-misses or noise
    task automatic fill_window(int base, int len);
        logic signed [rmq_pkg::DATA_W-1:0] dominant;
        logic signed [rmq_pkg::DATA_W-1:0] val;
        int                                share;
        dominant = pick_value();
        share    = $urandom_range(30, 90);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(1, 100) <= share)
                val = dominant;
            else if ($urandom_range(0, 1) == 0)
                val = dominant ^ (32'sd1 << $urandom_range(0, 31));
            else
                val = pick_value();
            send_item(make_load(base + i, val));
        end
    endtask

    task automatic query_in_window(int base, int len);
        int l;
        int r;
        if ($urandom_range(0, 2) == 0)
        begin
            l = base;
            r = base + len - 1;
        end
        else
        begin
            l = base + $urandom_range(0, len - 1);
            r = base + $urandom_range(0, len - 1);
        end
        if ($urandom_range(0, 3) == 0)
            {l, r} = {r, l};
        send_item(make_query(l, r));
    endtask

    task automatic random_round();
        int lim;
        int wlen;
        int base;
        int l;
        int r;
        lim  = usable_length();
        wlen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 96) : $urandom_range(1, 16);
        if (lim > 0 && $urandom_range(0, 3) != 0)
        begin
            if (wlen > lim)
                wlen = lim;
            base = $urandom_range(0, lim - wlen);
        end
        else
            base = $urandom_range(0, rmq_pkg::DEPTH - wlen);
        fill_window(base, wlen);
        repeat ($urandom_range(1, 4)) query_in_window(base, wlen);
        if ($urandom_range(0, 3) == 0)
            send_item(make_load($urandom_range(0, rmq_pkg::DEPTH - 1), pick_value()));
        if ($urandom_range(0, 2) == 0)
        begin
            l = $urandom_range(0, rmq_pkg::DEPTH - 1);
            r = $urandom_range(0, rmq_pkg::DEPTH - 1);
            if (reads_loaded(l, r))
                send_item(make_query(l, r));
        end
    endtask

    // reset length; extreme values, single positions, reversed bounds, ties, zero majority
    task automatic test_bounds_and_values();
        send_item(make_load(0, MOST_NEGATIVE));
        send_item(make_load(1, MOST_NEGATIVE));
        send_item(make_load(2, 32'sd5));
        send_item(make_load(3, '0));
        send_item(make_load(4, '0));
        send_item(make_load(1022, -32'sd1));
        send_item(make_load(1023, MOST_POSITIVE));
        send_item(make_query(0, 0));
        send_item(make_query(1, 0));
        send_item(make_query(0, 2));
        send_item(make_query(2, 4));
        send_item(make_query(0, 3));
        send_item(make_query(1023, 1022));
        send_item(make_query(1023, 1023));
    endtask

    task automatic test_length_extremes();
        write_length(rmq_pkg::LEN_W'(1));
        send_item(make_query(0, 0));
        send_item(make_query(0, 1));
        write_length('0);
        send_item(make_query(0, 0));
        write_length('1);
        send_item(make_query(1023, 1023));
        send_item(make_query(1023, 1022));
        write_length(rmq_pkg::LEN_W'(1023));
        send_item(make_query(1023, 0));
        send_item(make_query(1022, 1022));
    endtask

    // result side holds off while queries keep coming, then the sender waits for all results
    task automatic test_input_backpressure();
        write_length(rmq_pkg::ARRAY_LENGTH_RESET);
        fill_window(600, 8);
        holdoff_request = 300;
        repeat (10) query_in_window(600, 8);
        wait_drained();
        repeat (3) query_in_window(600, 8);
    endtask

    task automatic test_random_traffic(logic [rmq_pkg::LEN_W-1:0] len, int budget);
        int stop;
        write_length(len);
        stop = items_sent + budget;
        while (items_sent < stop)
            random_round();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_bounds_and_values();
        test_length_extremes();
        test_input_backpressure();
        test_random_traffic(rmq_pkg::ARRAY_LENGTH_RESET, 50);
        test_random_traffic(rmq_pkg::LEN_W'($urandom_range(1, 1024)), 45);
        test_random_traffic('1, 40);
        test_random_traffic(rmq_pkg::LEN_W'($urandom_range(1, 40)), 35);
        idling_on = 1'b0;
        test_random_traffic(rmq_pkg::ARRAY_LENGTH_RESET, 45);

        wait_drained();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // result-side stall: random bursts, or one long hold-off on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_request > 0)
            begin
                n = holdoff_request;
                holdoff_request = 0;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        rmq_pkg::out_item_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result transfer with no query pending: majority_value %0d",
                       out_data.majority_value);
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (out_data.majority_value !== want.majority_value)
                begin
                    $error("majority_value: expected %0d, actual %0d",
                           want.majority_value, out_data.majority_value);
                    error_count++;
                end
                if (out_data.has_majority !== want.has_majority)
                begin
                    $error("has_majority: expected %0d, actual %0d",
                           want.has_majority, out_data.has_majority);
                    error_count++;
                end
                if (out_data.out_of_range !== want.out_of_range)
                begin
                    $error("out_of_range: expected %0d, actual %0d",
                           want.out_of_range, out_data.out_of_range);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
